FILE: hdl/bdlp_pkg.sv
package bdlp_pkg;

    localparam int SAMPLE_W = 8;
    localparam int COUNT_W  = 8;
    localparam int PHASE_W  = 3;
    localparam int EVENT_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [PHASE_W-1:0] PH_RELEASED   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RISING     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PRESS_DB   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PRESSED    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FALLING    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_RELEASE_DB = 3'd5;

    localparam logic [EVENT_W-1:0] EV_LONG_PRESS = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_MASK      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd2;

    localparam logic [SAMPLE_W-1:0] RST_BUTTON_MASK      = 8'd1;
    localparam logic [COUNT_W-1:0]  RST_DEBOUNCE_TICKS   = 8'd5;
    localparam logic [COUNT_W-1:0]  RST_LONG_PRESS_TICKS = 8'd100;

    typedef struct packed {
        logic [SAMPLE_W-1:0] button_mask;
        logic [COUNT_W-1:0]  debounce_ticks;
        logic [COUNT_W-1:0]  long_press_ticks;
    } t_cfg;

endpackage

FILE: hdl/button_debounce_long_press_core.sv
// Push-button debouncer with long-press detection. Each word on the slave
// stream is one timer-tick sample of the raw port; the button counts as
// pressed when every bit of button_mask is set in it. For every accepted
// word exactly one registered result word follows: the phase code after
// the update (0 released, 1 rising, 2 press debounce, 3 pressed, 4 falling,
// 5 release debounce) or 6 on the single tick a long press is reported.
// A word is taken every cycle unless the output stalls; the phase update
// from sample to result register is combinational, and a stalled result
// stops intake only until it is taken. Write registers over the config
// channel (0 button_mask, 1 debounce_ticks, 2 long_press_ticks) while idle.
module button_debounce_long_press_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,   // [7:0] port_sample
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [7:0]                     o_m_axis_tdata,   // [2:0] button_event, [7:3] zero
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdlp_pkg::COUNT_W-1:0]   i_cfg_data
);
    import bdlp_pkg::*;

    t_cfg               cfg;
    logic [EVENT_W-1:0] out_event;

    bdlp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bdlp_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_sample (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_event (out_event)
    );

    assign o_m_axis_tdata = {{(8 - EVENT_W){1'b0}}, out_event};

endmodule

FILE: hdl/bdlp_cfg.sv
module bdlp_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bdlp_pkg::COUNT_W-1:0]    i_cfg_data,
    output bdlp_pkg::t_cfg                  o_cfg
);
    import bdlp_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_mask      <= RST_BUTTON_MASK;
            r_cfg.debounce_ticks   <= RST_DEBOUNCE_TICKS;
            r_cfg.long_press_ticks <= RST_LONG_PRESS_TICKS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BUTTON_MASK:      r_cfg.button_mask      <= i_cfg_data;
                REG_DEBOUNCE_TICKS:   r_cfg.debounce_ticks   <= i_cfg_data;
                REG_LONG_PRESS_TICKS: r_cfg.long_press_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: hdl/bdlp_fsm.sv
module bdlp_fsm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bdlp_pkg::t_cfg                 i_cfg,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bdlp_pkg::SAMPLE_W-1:0]  i_in_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bdlp_pkg::EVENT_W-1:0]   o_out_event
);
    import bdlp_pkg::*;

    logic [PHASE_W-1:0] r_phase,    n_phase;
    logic [COUNT_W-1:0] r_db_cnt,   n_db_cnt;
    logic [COUNT_W-1:0] r_hold_cnt, n_hold_cnt;
    logic               r_reported, n_reported;
    logic               r_out_valid;
    logic [EVENT_W-1:0] r_out_event, n_out_event;
    logic               pressed;
    logic               accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_event = r_out_event;

    assign pressed = (i_in_sample & i_cfg.button_mask) == i_cfg.button_mask;

    always_comb begin
        n_phase    = r_phase;
        n_db_cnt   = r_db_cnt;
        n_hold_cnt = r_hold_cnt;
        n_reported = r_reported;
        unique case (r_phase)
            PH_RELEASED: begin
                if (pressed) n_phase = PH_RISING;
            end
            PH_RISING: begin
                n_hold_cnt = '0;
                n_reported = 1'b0;
                if (i_cfg.debounce_ticks != '0) begin
                    n_db_cnt = COUNT_W'(1);
                    n_phase  = PH_PRESS_DB;
                end else begin
                    n_db_cnt = '0;
                    n_phase  = PH_PRESSED;
                end
            end
            PH_PRESS_DB: begin
                if (r_db_cnt < i_cfg.debounce_ticks) n_db_cnt = r_db_cnt + COUNT_W'(1);
                else n_phase = PH_PRESSED;
            end
            PH_PRESSED: begin
                if (!pressed) begin
                    n_phase = PH_FALLING;
                end else if (!r_reported) begin
                    if (r_hold_cnt < i_cfg.long_press_ticks)
                        n_hold_cnt = r_hold_cnt + COUNT_W'(1);
                    else if (r_hold_cnt == i_cfg.long_press_ticks)
                        n_reported = 1'b1;
                end
            end
            PH_FALLING: begin
                if (i_cfg.debounce_ticks != '0) begin
                    n_db_cnt = COUNT_W'(1);
                    n_phase  = PH_RELEASE_DB;
                end else begin
                    n_db_cnt = '0;
                    n_phase  = PH_RELEASED;
                end
            end
            PH_RELEASE_DB: begin
                if (r_db_cnt < i_cfg.debounce_ticks) n_db_cnt = r_db_cnt + COUNT_W'(1);
                else n_phase = PH_RELEASED;
            end
            default: n_phase = PH_RELEASED;
        endcase
        n_out_event = (n_reported && !r_reported) ? EV_LONG_PRESS : EVENT_W'(n_phase);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RELEASED;
            r_db_cnt    <= '0;
            r_hold_cnt  <= '0;
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_db_cnt   <= n_db_cnt;
                r_hold_cnt <= n_hold_cnt;
                r_reported <= n_reported;
            end
            if (accept) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_out_event <= n_out_event;
    end

    a_long_press_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EV_LONG_PRESS) |-> r_reported)
        else $error("long-press word without report flag");

    a_report_in_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_reported && n_reported) |-> (r_phase == PH_PRESSED))
        else $error("long press reported outside pressed phase");

    a_accept_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted word produced no result");

    a_phase_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(accept)) |-> $stable(r_phase))
        else $error("phase moved without an accepted word");

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import bdlp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 100000;

    class debounce_scoreboard;
        logic [SAMPLE_W-1:0] mask;
        logic [COUNT_W-1:0]  db_ticks;
        logic [COUNT_W-1:0]  lp_ticks;
        logic [PHASE_W-1:0]  phase;
        logic [COUNT_W-1:0]  db_count;
        logic [COUNT_W-1:0]  hold_count;
        bit                  reported;
        logic [EVENT_W-1:0]  event_q[$];
        int                  errors;

        function new();
            mask       = RST_BUTTON_MASK;
            db_ticks   = RST_DEBOUNCE_TICKS;
            lp_ticks   = RST_LONG_PRESS_TICKS;
            phase      = PH_RELEASED;
            db_count   = '0;
            hold_count = '0;
            reported   = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
            case (idx)
                REG_BUTTON_MASK:      mask = val;
                REG_DEBOUNCE_TICKS:   db_ticks = val;
                REG_LONG_PRESS_TICKS: lp_ticks = val;
                default: ;
            endcase
        endfunction

        function void debounce_advance(logic [PHASE_W-1:0] nxt);
            if (db_count < db_ticks) begin
                db_count = db_count + COUNT_W'(1);
            end else begin
                phase = nxt;
            end
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            bit pressed;
            logic [EVENT_W-1:0] ev;
            pressed = ((s & mask) == mask);
            ev = 'x;
            case (phase)
                PH_RELEASED: begin
                    if (pressed) phase = PH_RISING;
                end
                PH_RISING: begin
                    db_count   = '0;
                    hold_count = '0;
                    reported   = 1'b0;
                    phase      = PH_PRESS_DB;
                    debounce_advance(PH_PRESSED);
                end
                PH_PRESS_DB: debounce_advance(PH_PRESSED);
                PH_PRESSED: begin
                    if (!pressed) begin
                        phase = PH_FALLING;
                    end else if (!reported) begin
                        if (hold_count < lp_ticks) begin
                            hold_count = hold_count + COUNT_W'(1);
                        end else if (hold_count == lp_ticks) begin
                            reported = 1'b1;
                            ev = EV_LONG_PRESS;
                        end
                    end
                end
                PH_FALLING: begin
                    db_count = '0;
                    phase    = PH_RELEASE_DB;
                    debounce_advance(PH_RELEASED);
                end
                PH_RELEASE_DB: debounce_advance(PH_RELEASED);
                default: phase = PH_RELEASED;
            endcase
            if (ev !== EV_LONG_PRESS) ev = phase;
            event_q.push_back(ev);
        endfunction

        function void check_result(logic [7:0] data);
            logic [EVENT_W-1:0] exp_ev;
            if (event_q.size() == 0) begin
                $error("button_event: expected none, actual %0d", data[2:0]);
                errors++;
                return;
            end
            exp_ev = event_q.pop_front();
            if (data[2:0] !== exp_ev) begin
                $error("button_event mismatch: expected %0d, actual %0d", exp_ev, data[2:0]);
                errors++;
            end
            if (data[7:3] !== 5'd0) begin
                $error("tdata pad mismatch: expected 0, actual %0d", data[7:3]);
                errors++;
            end
        endfunction

        function int pending();
            return event_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [7:0]           o_m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COUNT_W-1:0]   i_cfg_data = '0;

    debounce_scoreboard sb;
    int send_idle = 28;
    int recv_idle = 61;
    int cycles = 0;

    button_debounce_long_press_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) sb.note_sample(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("button_debounce_long_press_core test failed");
            $finish;
        end
    end

    function automatic logic [7:0] pressed_sample(logic [7:0] m);
        return 8'($urandom) | m;
    endfunction

    function automatic logic [7:0] released_sample(logic [7:0] m);
        logic [7:0] s;
        logic [2:0] b;
        s = 8'($urandom);
        if (m == 8'd0) return s;
        do b = 3'($urandom_range(7)); while (!m[b]);
        s[b] = 1'b0;
        return s;
    endfunction

    task automatic send_sample(input logic [7:0] s);
        if ($urandom_range(99) < send_idle) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic program_regs(input logic [7:0] m, input logic [7:0] db,
                                input logic [7:0] lp);
        write_reg(REG_BUTTON_MASK, m);
        write_reg(REG_DEBOUNCE_TICKS, db);
        write_reg(REG_LONG_PRESS_TICKS, lp);
        write_reg(REG_UNUSED, 8'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_setting(input logic [7:0] m, input logic [7:0] db,
                               input logic [7:0] lp, input int budget, input bit hold_mid);
        int sent;
        int len;
        int kind;
        sent = 0;
        wait_idle();
        program_regs(m, db, lp);
        while (sent < budget) begin
            kind = $urandom_range(99);
            if (hold_mid && sent >= budget / 2) begin
                // drain everything before carrying on
                wait_idle();
                hold_mid = 1'b0;
            end
            if (kind < 75) begin
                if ($urandom_range(1))
                    len = int'(db) + int'(lp) + 2 + $urandom_range(6);
                else
                    len = $urandom_range(1, int'(db) + int'(lp) + 2);
                for (int k = 0; k < len && sent < budget; k++) begin
                    send_sample(pressed_sample(m));
                    sent++;
                end
                len = $urandom_range(1, int'(db) + 4);
                for (int k = 0; k < len && sent < budget; k++) begin
                    send_sample(released_sample(m));
                    sent++;
                end
            end else begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len && sent < budget; k++) begin
                    send_sample(8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: mask bit 0, debounce 5
        send_sample(8'h00);
        send_sample(8'hFE);
        send_sample(8'hFF);
        repeat (5) send_sample(8'h00);
        send_sample(8'h00);
        send_sample(8'h01);
        wait_idle();

        // empty mask: every word counts as pressed
        program_regs(8'h00, 8'h00, 8'd2);
        repeat (6) send_sample(8'h00);
        wait_idle();
        program_regs(8'hFF, 8'h00, 8'd6);
        send_sample(8'hFE);
        send_sample(8'h7F);
        send_sample(8'hFF);
        repeat (4) send_sample(8'hFF);
        wait_idle();

        // lower the limit below the running hold count
        program_regs(8'hFF, 8'h00, 8'd1);
        repeat (3) send_sample(8'hFF);
        send_sample(8'h00);
        send_sample(8'h00);

        run_setting(8'h81, 8'd0, 8'd0, 200, 1'b0);
        run_setting(8'hFF, 8'd255, 8'd3, 300, 1'b0);
        send_idle = 61;
        recv_idle = 28;
        run_setting(8'h00, 8'd2, 8'd255, 300, 1'b0);
        run_setting(8'h3C, 8'd1, 8'd254, 300, 1'b0);
        send_idle = 0;
        recv_idle = 0;
        run_setting(8'($urandom), 8'($urandom_range(4)), 8'($urandom_range(12)), 225, 1'b1);
        run_setting(8'($urandom), 8'($urandom_range(4)), 8'($urandom_range(12)), 225, 1'b0);

        wait_idle();
        if (sb.errors == 0) begin
            $display("button_debounce_long_press_core test passed");
        end else begin
            $display("button_debounce_long_press_core test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/bdlp_pkg.sv
hdl/bdlp_cfg.sv
hdl/bdlp_fsm.sv
hdl/button_debounce_long_press_core.sv
test/tb.sv
